### rtl/fjsop_pkg.sv
// ============================================================================
// Flat JSON string-object parser package
// Shared types, parse phases, result kinds, error codes and byte helpers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fjsop_pkg;

    // Default width of the saturating byte position counter.
    localparam int POS_BITS_DEF = 32;

    // Width of the byte position field on the result channel.
    localparam int POS_OUT_W = 32;

    // Parse phases.
    typedef enum logic [3:0] {
        PH_START        = 4'd0,
        PH_BOM1         = 4'd1,
        PH_BOM2         = 4'd2,
        PH_OPEN         = 4'd3,
        PH_AFTER_OPEN   = 4'd4,
        PH_STRING_START = 4'd5,
        PH_IN_STRING    = 4'd6,
        PH_ESCAPE       = 4'd7,
        PH_UNICODE      = 4'd8,
        PH_COLON        = 4'd9,
        PH_AFTER_VALUE  = 4'd10,
        PH_TRAILING     = 4'd11,
        PH_ERROR        = 4'd12
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // Error codes.
    localparam logic [3:0] ERR_OPEN_BRACE  = 4'd0;
    localparam logic [3:0] ERR_COLON       = 4'd1;
    localparam logic [3:0] ERR_QUOTE       = 4'd2;
    localparam logic [3:0] ERR_ESCAPE_END  = 4'd3;
    localparam logic [3:0] ERR_SHORT_UNI   = 4'd4;
    localparam logic [3:0] ERR_BAD_HEX     = 4'd5;
    localparam logic [3:0] ERR_BAD_ESCAPE  = 4'd6;
    localparam logic [3:0] ERR_STRING_END  = 4'd7;
    localparam logic [3:0] ERR_EMPTY_KEY   = 4'd8;
    localparam logic [3:0] ERR_SEPARATOR   = 4'd9;
    localparam logic [3:0] ERR_TRAILING    = 4'd10;
    localparam logic [3:0] ERR_NONE        = 4'd0;

    // Characters of interest.
    localparam logic [7:0] CH_BOM0      = 8'hEF;
    localparam logic [7:0] CH_BOM1      = 8'hBB;
    localparam logic [7:0] CH_BOM2      = 8'hBF;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_U     = 8'h75;

    // UTF-8 encoding limits and marks.
    localparam logic [15:0] UTF_MAX1 = 16'h007F;
    localparam logic [15:0] UTF_MAX2 = 16'h07FF;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;

    // One result item.
    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             data;
        logic                   is_key;
        logic [3:0]             code;
        logic [POS_OUT_W-1:0]   pos;
    } res_t;

    // All results raised by one input item.
    typedef struct packed {
        logic [1:0]      last_idx;
        res_t [3:0]      res;
    } group_t;

    // Whitespace between tokens: tab through carriage return, and space.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Hex digit decode; bit 4 flags a valid digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/flat_json_string_object_parser.sv
// ============================================================================
// Flat JSON string-object parser
// Streams a flat object of string keys and values, one byte per item, and
// produces unescaped string bytes, end marks, object-done or errors.
// ============================================================================
// Usage:
//   Item channel: item_valid / item_stall carry in_byte and end_of_file.
//   end_of_file flags the final byte of a text; the parser returns to its
//   reset state right after that byte.
//   Result channel: result_valid / result_stall carry kind, data_byte,
//   is_key, error_code, byte_position and last_of_run. Each input item
//   raises zero to four results; last_of_run marks the final one.
//   An accepted item's results are registered into the queue below and
//   reach the port once earlier groups drain. Throughput: one item per cycle
//   while each item raises at most one result and result_stall is low; an
//   item with more results holds the single port, draining one per cycle.
//   A two-entry queue of result groups sits between the parser and the
//   result port, so items keep flowing while a finished result waits.
//   item_stall rises only when both queue entries are occupied.
//   Reset clears the parser state, the position counter and the queue;
//   no results are pending afterwards. A stalled result holds steady.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module flat_json_string_object_parser
    import fjsop_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 end_of_file,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [1:0]                kind,
    output logic [7:0]                data_byte,
    output logic                      is_key,
    output logic [3:0]                error_code,
    output logic [POS_OUT_W-1:0]      byte_position,
    output logic                      last_of_run
);

    localparam int EXT_W = (POSITION_BITS > POS_OUT_W) ? POSITION_BITS : POS_OUT_W;

    // Parser state.
    phase_t                   ph_reg, ph_next;
    logic                     key_reg, key_next;
    logic [1:0]               hex_reg, hex_next;
    logic [15:0]              acc_reg, acc_next;
    logic                     khb_reg, khb_next;
    logic [POSITION_BITS-1:0] cnt_reg, cnt_next;

    // Result group queue.
    group_t                   grp_mem [2];
    logic                     wr_ptr_reg, rd_ptr_reg;
    logic [1:0]               fill_reg, fill_next;
    logic [1:0]               sub_reg, sub_next;

    // Decode helpers.
    logic                     accept;
    logic                     fail_now;
    logic [3:0]               fail_code;
    logic                     fail_at_zero;
    logic                     esc_ok;
    logic [7:0]               esc_byte;
    logic [4:0]               hx;
    logic [15:0]              acc_new;
    logic [EXT_W-1:0]         pos_ext, next_ext;
    logic [POS_OUT_W-1:0]     pos32, next32;
    res_t [3:0]               tb_res;
    logic [1:0]               tb_cnt;
    logic                     tb_byte;
    res_t                     fin_res;
    logic                     fin_en;
    group_t                   grp_new;
    logic [2:0]               n_res;
    logic                     push, pop, pop_grp;
    group_t                   head;
    res_t                     cur;

    assign accept   = item_valid && !item_stall;
    assign cnt_next = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
    assign pos_ext  = EXT_W'(cnt_reg);
    assign next_ext = EXT_W'(cnt_next);
    assign pos32    = pos_ext[POS_OUT_W-1:0];
    assign next32   = next_ext[POS_OUT_W-1:0];
    assign hx       = hex_decode(in_byte);
    assign acc_new  = {acc_reg[11:0], hx[3:0]};

    // Simple escape translation.
    always_comb
    begin
        esc_ok   = 1'b1;
        esc_byte = in_byte;
        unique case (in_byte)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: esc_byte = in_byte;
            CH_LOW_B: esc_byte = 8'h08;
            CH_LOW_F: esc_byte = 8'h0C;
            CH_LOW_N: esc_byte = 8'h0A;
            CH_LOW_R: esc_byte = 8'h0D;
            CH_LOW_T: esc_byte = 8'h09;
            default:  esc_ok = 1'b0;
        endcase
    end

    // Next state of the parser for one byte, and any error it raises.
    always_comb
    begin
        ph_next      = ph_reg;
        key_next     = key_reg;
        hex_next     = hex_reg;
        acc_next     = acc_reg;
        khb_next     = khb_reg;
        fail_now     = 1'b0;
        fail_code    = ERR_NONE;
        fail_at_zero = 1'b0;
        unique case (ph_reg)
            PH_START, PH_OPEN:
            begin
                if ((ph_reg == PH_START) && (in_byte == CH_BOM0))
                begin
                    ph_next = PH_BOM1;
                end
                else if (in_byte == CH_LBRACE)
                begin
                    ph_next = PH_AFTER_OPEN;
                end
                else if (!is_ws(in_byte))
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_OPEN_BRACE;
                end
            end
            PH_BOM1:
            begin
                if (in_byte == CH_BOM1)
                begin
                    ph_next = PH_BOM2;
                end
                else
                begin
                    fail_now     = 1'b1;
                    fail_code    = ERR_OPEN_BRACE;
                    fail_at_zero = 1'b1;
                end
            end
            PH_BOM2:
            begin
                if (in_byte == CH_BOM2)
                begin
                    ph_next = PH_OPEN;
                end
                else
                begin
                    fail_now     = 1'b1;
                    fail_code    = ERR_OPEN_BRACE;
                    fail_at_zero = 1'b1;
                end
            end
            PH_AFTER_OPEN:
            begin
                if (in_byte == CH_RBRACE)
                begin
                    ph_next = PH_TRAILING;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    key_next = 1'b1;
                    khb_next = 1'b0;
                    ph_next  = PH_IN_STRING;
                end
                else if (!is_ws(in_byte))
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_QUOTE;
                end
            end
            PH_STRING_START:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    if (key_reg)
                    begin
                        khb_next = 1'b0;
                    end
                    ph_next = PH_IN_STRING;
                end
                else if (!is_ws(in_byte))
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_QUOTE;
                end
            end
            PH_IN_STRING:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    if (key_reg && !khb_reg)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_EMPTY_KEY;
                    end
                    else
                    begin
                        ph_next = key_reg ? PH_COLON : PH_AFTER_VALUE;
                    end
                end
                else if (in_byte == CH_BACKSLASH)
                begin
                    ph_next = PH_ESCAPE;
                end
                else if (key_reg)
                begin
                    khb_next = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if (in_byte == CH_LOW_U)
                begin
                    ph_next  = PH_UNICODE;
                    hex_next = 2'd0;
                    acc_next = 16'd0;
                end
                else if (esc_ok)
                begin
                    ph_next = PH_IN_STRING;
                    if (key_reg)
                    begin
                        khb_next = 1'b1;
                    end
                end
                else
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_BAD_ESCAPE;
                end
            end
            PH_UNICODE:
            begin
                if (!hx[4])
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_BAD_HEX;
                end
                else
                begin
                    acc_next = acc_new;
                    if (hex_reg == 2'd3)
                    begin
                        hex_next = 2'd0;
                        ph_next  = PH_IN_STRING;
                        if (key_reg)
                        begin
                            khb_next = 1'b1;
                        end
                    end
                    else
                    begin
                        hex_next = hex_reg + 2'd1;
                    end
                end
            end
            PH_COLON:
            begin
                if (in_byte == CH_COLON)
                begin
                    key_next = 1'b0;
                    ph_next  = PH_STRING_START;
                end
                else if (!is_ws(in_byte))
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_COLON;
                end
            end
            PH_AFTER_VALUE:
            begin
                if (in_byte == CH_COMMA)
                begin
                    key_next = 1'b1;
                    ph_next  = PH_STRING_START;
                end
                else if (in_byte == CH_RBRACE)
                begin
                    ph_next = PH_TRAILING;
                end
                else if (!is_ws(in_byte))
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_SEPARATOR;
                end
            end
            PH_TRAILING:
            begin
                if (!is_ws(in_byte))
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_TRAILING;
                end
            end
            default:
            begin
                ph_next = ph_reg;
            end
        endcase
        if (fail_now)
        begin
            ph_next = PH_ERROR;
        end
    end

    // Results raised by the byte itself: bytes, end marks or an error.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            tb_res[i] = '{kind: KIND_BYTE, data: 8'd0, is_key: key_reg,
                          code: ERR_NONE, pos: pos32};
        end
        tb_cnt  = 2'd0;
        tb_byte = 1'b0;
        if (fail_now)
        begin
            tb_res[0] = '{kind: KIND_ERROR, data: 8'd0, is_key: 1'b0, code: fail_code,
                          pos: fail_at_zero ? '0 : pos32};
            tb_cnt    = 2'd1;
        end
        else
        begin
            priority case (ph_reg)
                PH_IN_STRING:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        tb_res[0].kind = KIND_END;
                        tb_cnt         = 2'd1;
                    end
                    else if (in_byte != CH_BACKSLASH)
                    begin
                        tb_res[0].data = in_byte;
                        tb_cnt         = 2'd1;
                        tb_byte        = 1'b1;
                    end
                end
                PH_ESCAPE:
                begin
                    if (in_byte != CH_LOW_U)
                    begin
                        tb_res[0].data = esc_byte;
                        tb_cnt         = 2'd1;
                        tb_byte        = 1'b1;
                    end
                end
                PH_UNICODE:
                begin
                    if (hex_reg == 2'd3)
                    begin
                        tb_byte = 1'b1;
                        if (acc_new <= UTF_MAX1)
                        begin
                            tb_res[0].data = acc_new[7:0];
                            tb_cnt         = 2'd1;
                        end
                        else if (acc_new <= UTF_MAX2)
                        begin
                            tb_res[0].data = UTF_LEAD2 | {3'd0, acc_new[10:6]};
                            tb_res[1].data = UTF_CONT | {2'd0, acc_new[5:0]};
                            tb_cnt         = 2'd2;
                        end
                        else
                        begin
                            tb_res[0].data = UTF_LEAD3 | {4'd0, acc_new[15:12]};
                            tb_res[1].data = UTF_CONT | {2'd0, acc_new[11:6]};
                            tb_res[2].data = UTF_CONT | {2'd0, acc_new[5:0]};
                            tb_cnt         = 2'd3;
                        end
                    end
                end
                default:
                begin
                    tb_cnt = 2'd0;
                end
            endcase
        end
    end

    // Result raised by the end of the text.
    always_comb
    begin
        fin_en  = end_of_file && !fail_now;
        fin_res = '{kind: KIND_ERROR, data: 8'd0, is_key: 1'b0, code: ERR_NONE,
                    pos: next32};
        unique case (ph_next)
            PH_START, PH_OPEN: fin_res.code = ERR_OPEN_BRACE;
            PH_BOM1, PH_BOM2:
            begin
                fin_res.code = ERR_OPEN_BRACE;
                fin_res.pos  = '0;
            end
            PH_AFTER_OPEN, PH_STRING_START: fin_res.code = ERR_QUOTE;
            PH_IN_STRING:   fin_res.code = ERR_STRING_END;
            PH_ESCAPE:      fin_res.code = ERR_ESCAPE_END;
            PH_UNICODE:     fin_res.code = ERR_SHORT_UNI;
            PH_COLON:       fin_res.code = ERR_COLON;
            PH_AFTER_VALUE: fin_res.code = ERR_SEPARATOR;
            PH_TRAILING:    fin_res.kind = KIND_DONE;
            default:        fin_en = 1'b0;
        endcase
    end

    // Gather the group of results for this item.
    always_comb
    begin
        n_res = {1'b0, tb_cnt} + {2'd0, fin_en};
        for (int i = 0; i < 4; i++)
        begin
            grp_new.res[i] = (i < int'(tb_cnt)) ? tb_res[i[1:0]] : fin_res;
        end
        grp_new.last_idx = 2'(n_res - 3'd1);
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_START;
            key_reg <= 1'b1;
            hex_reg <= 2'd0;
            acc_reg <= 16'd0;
            khb_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_file)
            begin
                ph_reg  <= PH_START;
                key_reg <= 1'b1;
                hex_reg <= 2'd0;
                acc_reg <= 16'd0;
                khb_reg <= 1'b0;
                cnt_reg <= '0;
            end
            else
            begin
                ph_reg  <= ph_next;
                key_reg <= key_next;
                hex_reg <= hex_next;
                acc_reg <= acc_next;
                khb_reg <= khb_next | (key_reg & tb_byte);
                cnt_reg <= cnt_next;
            end
        end
    end

    // Result queue control.
    assign head         = grp_mem[rd_ptr_reg];
    assign cur          = head.res[sub_reg];
    assign result_valid = (fill_reg != 2'd0);
    assign item_stall   = (fill_reg == 2'd2);
    assign push         = accept && (n_res != 3'd0);
    assign pop          = result_valid && !result_stall;
    assign pop_grp      = pop && (sub_reg == head.last_idx);
    assign fill_next    = fill_reg + {1'b0, push} - {1'b0, pop_grp};
    assign sub_next     = pop_grp ? 2'd0 : (pop ? sub_reg + 2'd1 : sub_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            sub_reg  <= sub_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_grp)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Result group storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            grp_mem[wr_ptr_reg] <= grp_new;
        end
    end

    // Result port.
    assign kind          = cur.kind;
    assign data_byte     = cur.data;
    assign is_key        = cur.is_key;
    assign error_code    = cur.code;
    assign byte_position = cur.pos;
    assign last_of_run   = (sub_reg == head.last_idx);

    // The queue never holds more than its two entries.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 2'd2)
        else $error("result queue overfilled");

    // The run index never passes the last result of the head group.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (sub_reg <= head.last_idx))
        else $error("run index beyond group end");

    // A stalled result keeps its place in the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(sub_reg) && $stable(rd_ptr_reg))
        else $error("stalled result moved");

    // The final byte of a text returns the parser to its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_file) |=> (ph_reg == PH_START) && (cnt_reg == '0) && key_reg)
        else $error("parser not reset after end of text");

endmodule

`default_nettype wire
